@@ rtl/wbss_pkg.sv @@
// package for the wildcard byte signature scan core
// field widths, configuration register codes
// no dependencies
package wbss_pkg;

    // field widths
    localparam int DATA_W = 8;
    localparam int ADDR_W = 64;
    localparam int CFG_W  = 64;
    localparam int MASK_W = 16;
    localparam int PLEN_W = 5;
    localparam int CIDX_W = 2;

    // configuration register index codes
    typedef enum logic [CIDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_CARE_MASK      = 2'd2,
        REG_PATTERN_LENGTH = 2'd3
    } cfg_reg_t;

endpackage

@@ rtl/wildcard_byte_signature_scan_core.sv @@
// wildcard byte signature scan core: masked signature search over a byte stream
// depends on wbss_pkg
//
//  channel   dir   handshake                 payload
//  input     in    in_valid / in_ready       data_byte, byte_address
//  result    out   out_valid / out_ready     match_address
//  config    in    cfg_write                 cfg_index, cfg_data
//
// one byte per cycle unless a match waits on a full, stalled result register:
// the input register feeds one pass of parallel masked compares, and the
// result register takes each match
// reset clears the run count, expected address, valid flags and config registers
// but sets pattern_length to one; the byte window holds no reset value
// a stall on the result side holds the input register only when it holds a match
module wildcard_byte_signature_scan_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wbss_pkg::DATA_W-1:0]   data_byte,
    input  logic [wbss_pkg::ADDR_W-1:0]   byte_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wbss_pkg::ADDR_W-1:0]   match_address,
    input  logic                          cfg_write,
    input  logic [wbss_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [wbss_pkg::CFG_W-1:0]    cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // configuration registers
    logic [wbss_pkg::CFG_W-1:0]   pattern_low_reg;
    logic [wbss_pkg::CFG_W-1:0]   pattern_high_reg;
    logic [wbss_pkg::MASK_W-1:0]  care_mask_reg;
    logic [wbss_pkg::PLEN_W-1:0]  pattern_length_reg;

    // input register
    logic                         in_valid_reg;
    logic [wbss_pkg::DATA_W-1:0]  data_reg;
    logic [wbss_pkg::ADDR_W-1:0]  addr_reg;

    // scan state
    logic [wbss_pkg::DATA_W-1:0]  window_reg [MAX_PATTERN];
    logic [wbss_pkg::DATA_W-1:0]  window_next [MAX_PATTERN];
    logic [LEN_W-1:0]             run_count_reg;
    logic [LEN_W-1:0]             run_count_next;
    logic [wbss_pkg::ADDR_W-1:0]  expected_reg;

    // result register
    logic                         out_valid_reg;
    logic [wbss_pkg::ADDR_W-1:0]  match_addr_reg;

    logic [LEN_W-1:0]             eff_len;
    logic [LEN_W-1:0]             cnt_base;
    logic [LEN_W-1:0]             cnt_inc;
    logic [2*wbss_pkg::CFG_W-1:0] sig_bytes;
    logic [MAX_PATTERN-1:0]       byte_ok;
    logic                         match;
    logic                         advance;
    logic [wbss_pkg::ADDR_W-1:0]  match_addr_next;

    // effective length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (pattern_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (pattern_length_reg > wbss_pkg::PLEN_W'(MAX_PATTERN))
            eff_len = LEN_W'(MAX_PATTERN);
        else
            eff_len = LEN_W'(pattern_length_reg);
    end

    // run count restarts on an address gap, then counts this byte
    always_comb
    begin
        cnt_base = (addr_reg != expected_reg) ? '0 : run_count_reg;
        if (cnt_base < LEN_W'(MAX_PATTERN))
            cnt_inc = cnt_base + LEN_W'(1);
        else
            cnt_inc = cnt_base;
    end

    // window after taking in the new byte, entry 0 newest
    always_comb
    begin
        window_next[0] = data_reg;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // parallel masked compares, signature byte j against entry len-1-j
    assign sig_bytes = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        logic [LEN_W-1:0] diff;
        logic [IDX_W-1:0] idx;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            diff = eff_len - LEN_W'(1) - LEN_W'(j);
            idx  = (LEN_W'(j) < eff_len) ? diff[IDX_W-1:0] : '0;
            byte_ok[j] = (LEN_W'(j) >= eff_len) || !care_mask_reg[j] ||
                         (window_next[idx] == sig_bytes[8*j +: 8]);
        end
    end

    assign match = (cnt_inc >= eff_len) && (&byte_ok);
    assign match_addr_next = addr_reg - (wbss_pkg::ADDR_W'(eff_len) - 64'd1);

    // input register moves on unless a match finds the result slot full
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready || !match);
    assign in_ready = !in_valid_reg || advance;
    assign run_count_next = match ? '0 : cnt_inc;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= wbss_pkg::PLEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (wbss_pkg::cfg_reg_t'(cfg_index))
                wbss_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                wbss_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                wbss_pkg::REG_CARE_MASK:
                    care_mask_reg <= cfg_data[wbss_pkg::MASK_W-1:0];
                wbss_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[wbss_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            addr_reg <= byte_address;
        end
    end

    // scan control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
            expected_reg  <= '0;
        end
        else if (advance)
        begin
            run_count_reg <= run_count_next;
            expected_reg  <= addr_reg + 64'd1;
        end
    end

    // byte window shift
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && match)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && match)
            match_addr_reg <= match_addr_next;
    end

    assign out_valid     = out_valid_reg;
    assign match_address = match_addr_reg;

endmodule

@@ rtl/wbss_checker.sv @@
// port level checks for the wildcard byte signature scan core
// depends on wbss_pkg, bound to wildcard_byte_signature_scan_core
// sees only the top level ports
module wbss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [wbss_pkg::DATA_W-1:0]   data_byte,
    input logic [wbss_pkg::ADDR_W-1:0]   byte_address,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [wbss_pkg::ADDR_W-1:0]   match_address,
    input logic                          cfg_write,
    input logic [wbss_pkg::CIDX_W-1:0]   cfg_index,
    input logic [wbss_pkg::CFG_W-1:0]    cfg_data
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_address))
        else $error("result word changed while stalled");

    // input stalls only behind a full, stalled result slot
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without result backpressure");

    // a fresh result follows an accepted byte, through the input and result registers
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching accepted byte");

endmodule

bind wildcard_byte_signature_scan_core wbss_checker u_wbss_checker (.*);

@@ dv/tb_wildcard_byte_signature_scan_core.sv @@
// testbench for wildcard_byte_signature_scan_core: masked signature search on a byte stream
// predicts match start addresses with its own scanner model and checks every result word
// depends on wbss_pkg and the core rtl
module tb_wildcard_byte_signature_scan_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 10;
    localparam int IDLE_PCT    = 22;

    typedef struct packed {
        logic [wbss_pkg::DATA_W-1:0] data;
        logic [wbss_pkg::ADDR_W-1:0] addr;
    } scan_word_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [wbss_pkg::DATA_W-1:0]   data_byte = '0;
    logic [wbss_pkg::ADDR_W-1:0]   byte_address = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [wbss_pkg::ADDR_W-1:0]   match_address;
    logic                          cfg_write = 1'b0;
    logic [wbss_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [wbss_pkg::CFG_W-1:0]    cfg_data = '0;

    // scanner model: configuration copy and search state
    logic [63:0]                   sig_lo = '0;
    logic [63:0]                   sig_hi = '0;
    logic [wbss_pkg::MASK_W-1:0]   care = '0;
    logic [wbss_pkg::PLEN_W-1:0]   plen_raw = 5'd1;
    logic [7:0]                    win [16];
    int                            run_len = 0;
    logic [wbss_pkg::ADDR_W-1:0]   next_addr = '0;

    // stimulus and checking bookkeeping
    scan_word_t                    pend_q[$];
    logic [wbss_pkg::ADDR_W-1:0]   match_q[$];
    logic [wbss_pkg::ADDR_W-1:0]   hit_addr;
    logic [wbss_pkg::ADDR_W-1:0]   want_addr;
    logic [wbss_pkg::ADDR_W-1:0]   gen_addr = '0;
    int                            pushed = 0;
    int                            accepted = 0;
    int                            matches_seen = 0;
    int                            fail_count = 0;
    int                            settings = 0;
    int                            quiet_cycles = 0;
    bit                            no_idle = 1'b0;

    wildcard_byte_signature_scan_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .byte_address  (byte_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_address (match_address),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // signature length in force, out of range values clamped
    function automatic int active_len();
        int len;
        len = int'(plen_raw);
        if (len == 0)
            len = 1;
        if (len > 16)
            len = 16;
        return len;
    endfunction

    function automatic logic [7:0] sig_at(input int j);
        logic [127:0] s;
        s = {sig_hi, sig_lo};
        return s[8*j +: 8];
    endfunction

    // shift one byte into the window, report a match start if the tail fits
    function automatic bit scan_byte(input logic [7:0] b, input logic [63:0] a,
                                     output logic [63:0] start);
        int len;
        bit ok;
        len = active_len();
        start = '0;
        if (a != next_addr)
            run_len = 0;
        for (int i = 15; i > 0; i--)
            win[i] = win[i-1];
        win[0] = b;
        if (run_len < 16)
            run_len++;
        next_addr = a + 64'd1;
        ok = (run_len >= len);
        for (int j = 0; j < 16; j++)
            if (ok && j < len && care[j] && win[len-1-j] != sig_at(j))
                ok = 1'b0;
        if (ok)
        begin
            start = a - 64'(len - 1);
            run_len = 0;
        end
        return ok;
    endfunction

    // driver: input words from the pending queue, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted++;
                if (scan_byte(data_byte, byte_address, hit_addr))
                    match_q.push_back(hit_addr);
            end
            if (!in_valid || in_ready)
            begin
                if (pend_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    data_byte    <= pend_q[0].data;
                    byte_address <= pend_q[0].addr;
                    in_valid     <= 1'b1;
                    void'(pend_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest predicted match
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                matches_seen++;
                if (match_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected match at %h", match_address));
                end
                else
                begin
                    want_addr = match_q.pop_front();
                    if (match_address !== want_addr)
                        report_mismatch($sformatf("match_address %h, expected %h",
                                                  match_address, want_addr));
                end
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        scan_word_t w;
        w.data = b;
        w.addr = gen_addr;
        pend_q.push_back(w);
        gen_addr = gen_addr + 64'd1;
        pushed++;
    endtask

    task automatic push_at(input logic [63:0] a, input logic [7:0] b);
        gen_addr = a;
        push_byte(b);
    endtask

    // one register write, mirrored into the model
    task automatic write_reg(input wbss_pkg::cfg_reg_t r, input logic [63:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        case (r)
            wbss_pkg::REG_PATTERN_LOW:    sig_lo = v;
            wbss_pkg::REG_PATTERN_HIGH:   sig_hi = v;
            wbss_pkg::REG_CARE_MASK:      care = v[wbss_pkg::MASK_W-1:0];
            wbss_pkg::REG_PATTERN_LENGTH: plen_raw = v[wbss_pkg::PLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] mask, input logic [63:0] len);
        write_reg(wbss_pkg::REG_PATTERN_LOW, lo);
        write_reg(wbss_pkg::REG_PATTERN_HIGH, hi);
        write_reg(wbss_pkg::REG_CARE_MASK, mask);
        write_reg(wbss_pkg::REG_PATTERN_LENGTH, len);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    // wait for all words to drain, then let the pipeline empty
    task automatic settle();
        while (accepted != pushed || match_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // random phase: mostly signature copies with random wildcard bytes,
    // plus noise, broken prefixes and address jumps
    task automatic gen_phase(input int target);
        int start;
        int len;
        int pick;
        int slot;
        int n;
        logic [7:0] b;
        start = pushed;
        len = active_len();
        while (pushed - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
                for (int k = 0; k < len; k++)
                begin
                    b = care[k] ? sig_at(k) : 8'($urandom);
                    if (k == slot)
                        b = b ^ (8'd1 << $urandom_range(0, 7));
                    push_byte(b);
                end
            end
            else if (pick < 78)
            begin
                n = $urandom_range(1, 8);
                repeat (n) push_byte(8'($urandom));
            end
            else if (pick < 88)
            begin
                n = $urandom_range(1, len);
                for (int k = 0; k < n; k++)
                    push_byte(sig_at(k));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: gen_addr = {$urandom, $urandom};
                    1: gen_addr = 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15));
                    2: gen_addr = gen_addr - 64'd1;
                    default: gen_addr = gen_addr + 64'($urandom_range(1, 5));
                endcase
            end
        end
    endtask

    // test sequence
    initial
    begin
        logic [63:0] mask_v;
        logic [63:0] len_v;
        int len_pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // 4-byte signature ff ?? 00 5a, junk above the mask and length fields
        configure(64'h0000_0000_5A00_00FF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_000D, 64'hFFFF_FFFF_FFFF_FFE4);
        // match running over the top of the address space
        push_at(64'hFFFF_FFFF_FFFF_FFFE, 8'hFF);
        push_byte(8'h12);
        push_byte(8'h00);
        push_byte(8'h5A);
        // address gap inside a would-be match
        push_at(64'd2, 8'hFF);
        push_byte(8'h00);
        push_at(64'd100, 8'h00);
        push_byte(8'h5A);
        // first byte off by one bit
        push_at(64'd300, 8'hFE);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h5A);
        settle();

        // length zero acts as one, all wildcards: every byte matches
        configure(64'd0, 64'd0, 64'd0, 64'd0);
        push_at(64'h8000_0000_0000_0000, 8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        settle();

        // random phases across settings, extremes first
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: len_pick = 1;
                1: len_pick = 16;
                2: len_pick = 0;
                3: len_pick = 31;
                4: len_pick = 17;
                default: len_pick = $urandom_range(1, 16);
            endcase
            case (p % 5)
                1: mask_v = 64'd0;
                2: mask_v = 64'h0000_0000_0000_FFFF;
                default: mask_v = 64'(16'($urandom | $urandom));
            endcase
            len_v = 64'(len_pick);
            if ($urandom_range(0, 1) == 1)
            begin
                mask_v[63:16] = 48'({$urandom, $urandom});
                len_v[63:5] = 59'({$urandom, $urandom});
            end
            configure({$urandom, $urandom}, {$urandom, $urandom}, mask_v, len_v);
            no_idle = (p == 6);
            gen_phase(108);
            settle();
            no_idle = 1'b0;
        end

        $display("scanned %0d bytes under %0d signature settings, %0d matches checked",
                 accepted, settings, matches_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
